// File: rtl/wav_header_parser_defines.svh
// ----------------------------------------------------------------------------
// wav header parser assertion macros
// concurrent check wrappers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef WAV_HEADER_PARSER_DEFINES_SVH
`define WAV_HEADER_PARSER_DEFINES_SVH

`ifndef SYNTH
// check held off while reset is active
`define WAVHP_ASSERT_RST(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// check at every edge, reset included
`define WAVHP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WAVHP_ASSERT_RST(lbl, clk, rstn, prop, msg)
`define WAVHP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: rtl/wavhp_pkg.sv
// ----------------------------------------------------------------------------
// wav header parser package
// shared types, tag words, result codes and result builders
// ----------------------------------------------------------------------------
package wavhp_pkg;

  // result kinds
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_ACCEPT  = 2'd1;
  localparam logic [1:0] KIND_REJECT  = 2'd2;

  // reject reasons
  localparam logic [2:0] ERR_SHORT   = 3'd0;
  localparam logic [2:0] ERR_TAG     = 3'd1;
  localparam logic [2:0] ERR_NOT_PCM = 3'd2;
  localparam logic [2:0] ERR_PARAMS  = 3'd3;
  localparam logic [2:0] ERR_NO_DATA = 3'd4;

  // tags, first character in the lowest byte
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  // header layout
  localparam logic [5:0]  OFF_CHUNK0   = 6'd36;
  localparam logic [5:0]  OFF_HDR_LAST = 6'd43;
  localparam logic [5:0]  OFF_CK_LAST  = 6'd7;
  localparam logic [15:0] FMT_PCM      = 16'd1;

  // result queue sizing
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [4:0] {
    PH_HEAD  = 5'b00001,
    PH_CHUNK = 5'b00010,
    PH_SKIP  = 5'b00100,
    PH_DATA  = 5'b01000,
    PH_DONE  = 5'b10000
  } wavhp_phase_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_in_file;
  } wavhp_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [15:0] channels;
    logic [31:0] sample_rate;
    logic [4:0]  bits_per_sample;
    logic [31:0] data_length;
    logic [2:0]  error_code;
    logic        last_of_run;
  } wavhp_result_t;

  typedef struct packed {
    logic          push0;
    logic          push1;
    wavhp_result_t res0;
    wavhp_result_t res1;
  } wavhp_push_t;

  typedef struct packed {
    logic [FIFO_CNT_W-1:0] count;
    logic                  space;
  } wavhp_fifo_stat_t;

  // pick one byte of a tag word
  function automatic logic [7:0] tag_byte(input logic [31:0] tag, input logic [1:0] idx);
    tag_byte = tag[{idx, 3'b000} +: 8];
  endfunction

  function automatic wavhp_result_t mk_payload(input logic [7:0] b);
    wavhp_result_t r;
    r = '0;
    r.kind = KIND_PAYLOAD;
    r.payload_byte = b;
    mk_payload = r;
  endfunction

  function automatic wavhp_result_t mk_accept(input logic [15:0] ch, input logic [31:0] rate,
                                              input logic [4:0] bits, input logic [31:0] len);
    wavhp_result_t r;
    r = '0;
    r.kind = KIND_ACCEPT;
    r.channels = ch;
    r.sample_rate = rate;
    r.bits_per_sample = bits;
    r.data_length = len;
    mk_accept = r;
  endfunction

  function automatic wavhp_result_t mk_reject(input logic [2:0] code);
    wavhp_result_t r;
    r = '0;
    r.kind = KIND_REJECT;
    r.error_code = code;
    mk_reject = r;
  endfunction

endpackage

// File: rtl/wav_header_parser.sv
// ----------------------------------------------------------------------------
// wav header parser
// byte-stream pcm wav header check with data chunk payload forwarding
// ----------------------------------------------------------------------------
// Takes a WAV file one byte per request on the in_ channel (in_tlast on the
// file's final byte) and accepts one byte every cycle while the result side
// keeps up. A byte passes an input register, a registered state update
// and a four-entry result queue, so its first result is offered once the
// byte has been written into the queue. Each byte yields at most two results:
// the byte that ends a data chunk gives its payload result and the accepted
// verdict, and the output then offers them one after the other; the input side
// stalls only when the result queue holds more than two entries. Every file ends
// in exactly one accepted or rejected result carrying out_tlast; bytes after an
// early verdict give nothing. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module wav_header_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // byte_value
  input  logic        in_tlast,   // last_in_file
  output logic        out_tvalid,
  input  logic        out_tready,
  // payload_byte, channels, sample_rate, bits_per_sample, data_length, error_code
  output logic [95:0] out_tdata,
  output logic [1:0]  out_tuser,  // kind
  output logic        out_tlast   // last_of_run
);
  import wavhp_pkg::*;
  `include "wav_header_parser_defines.svh"

  wavhp_item_t      in_item, item;
  logic             step;
  wavhp_push_t      push;
  wavhp_result_t    res;
  wavhp_fifo_stat_t stat;

  assign in_item.byte_value   = in_tdata;
  assign in_item.last_in_file = in_tlast;

  // input register
  wavhp_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .space    (stat.space),
    .step     (step),
    .item     (item)
  );

  // header and chunk logic
  wavhp_parser u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (item),
    .push  (push)
  );

  // result queue
  wavhp_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_res   (res),
    .stat      (stat)
  );

  // result packing, first field lowest
  assign out_tdata = {res.error_code, res.data_length, res.bits_per_sample,
                      res.sample_rate, res.channels, res.payload_byte};
  assign out_tuser = res.kind;
  assign out_tlast = res.last_of_run;

  // queue never overfills
  `WAVHP_ASSERT_RST(a_fifo_bound, clk, rst_n,
    stat.count <= FIFO_CNT_W'(FIFO_DEPTH), "result queue overfilled")
  // results are only produced for a byte taken while the queue had room
  `WAVHP_ASSERT_RST(a_push_space, clk, rst_n,
    (push.push0 || push.push1) |-> (step && stat.space), "result pushed without room")
  // a pair is always payload then final verdict
  `WAVHP_ASSERT_RST(a_pair_form, clk, rst_n,
    push.push1 |-> (push.push0 && push.res0.kind == KIND_PAYLOAD &&
    !push.res0.last_of_run && push.res1.kind == KIND_ACCEPT && push.res1.last_of_run),
    "malformed result pair")
  // queue empty after reset
  `WAVHP_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_tvalid, "results present after reset")

endmodule

// File: rtl/wavhp_in_reg.sv
// ----------------------------------------------------------------------------
// wav header parser input register
// holds one byte request until the parser has room to take it
// ----------------------------------------------------------------------------
module wavhp_in_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  wavhp_pkg::wavhp_item_t in_item,
  input  logic                 space,
  output logic                 step,
  output wavhp_pkg::wavhp_item_t item
);
  import wavhp_pkg::*;

  logic        valid_r, valid_nxt;
  wavhp_item_t item_r;

  // advance when the result queue can take two results
  assign step     = valid_r && space;
  assign in_ready = !valid_r || step;
  assign item     = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  // occupancy flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule

// File: rtl/wavhp_parser.sv
// ----------------------------------------------------------------------------
// wav header parser core
// per-byte header check, chunk walk and payload forwarding
// ----------------------------------------------------------------------------
module wavhp_parser (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  wavhp_pkg::wavhp_item_t item,
  output wavhp_pkg::wavhp_push_t push
);
  import wavhp_pkg::*;

  wavhp_phase_t phase_r, phase_nxt;
  logic [5:0]   off_r, off_nxt;
  logic         tags_r, tags_nxt;
  logic [15:0]  format_r, format_nxt;
  logic [15:0]  chan_r, chan_nxt;
  logic [31:0]  rate_r, rate_nxt;
  logic [15:0]  bits_r, bits_nxt;
  logic         cid_r, cid_nxt;
  logic [31:0]  size_r, size_nxt;
  logic [31:0]  left_r, left_nxt;
  logic [31:0]  deliv_r, deliv_nxt;

  logic [7:0]   b;
  logic         last;
  logic [5:0]   off_m36;
  logic [31:0]  left_dec;
  logic         chunk_en;
  logic [2:0]   chunk_pos;
  logic         acc, rej, cd, begin_ck, restart;
  logic [2:0]   err;
  wavhp_result_t acc_res, rej_res;

  assign b        = item.byte_value;
  assign last     = item.last_in_file;
  assign off_m36  = off_r - OFF_CHUNK0;
  assign left_dec = (left_r != 32'd0) ? (left_r - 32'd1) : 32'd0;

  always_comb begin
    phase_nxt  = phase_r;
    off_nxt    = off_r;
    tags_nxt   = tags_r;
    format_nxt = format_r;
    chan_nxt   = chan_r;
    rate_nxt   = rate_r;
    bits_nxt   = bits_r;
    cid_nxt    = cid_r;
    size_nxt   = size_r;
    left_nxt   = left_r;
    deliv_nxt  = deliv_r;
    chunk_en   = 1'b0;
    chunk_pos  = 3'd0;
    acc        = 1'b0;
    rej        = 1'b0;
    cd         = 1'b0;
    begin_ck   = 1'b0;
    restart    = 1'b0;
    err        = ERR_SHORT;
    push       = '0;

    // header field capture
    if (phase_r == PH_HEAD) begin
      if (off_r < 6'd4) begin
        if (b != tag_byte(TAG_RIFF, off_r[1:0])) tags_nxt = 1'b0;
      end else if (off_r >= 6'd8 && off_r < 6'd12) begin
        if (b != tag_byte(TAG_WAVE, off_r[1:0])) tags_nxt = 1'b0;
      end else if (off_r >= 6'd12 && off_r < 6'd16) begin
        if (b != tag_byte(TAG_FMT, off_r[1:0])) tags_nxt = 1'b0;
      end else if (off_r == 6'd20 || off_r == 6'd21) begin
        format_nxt[{off_r[0], 3'b000} +: 8] = format_r[{off_r[0], 3'b000} +: 8] | b;
      end else if (off_r == 6'd22 || off_r == 6'd23) begin
        chan_nxt[{off_r[0], 3'b000} +: 8] = chan_r[{off_r[0], 3'b000} +: 8] | b;
      end else if (off_r >= 6'd24 && off_r < 6'd28) begin
        rate_nxt[{off_r[1:0], 3'b000} +: 8] = rate_r[{off_r[1:0], 3'b000} +: 8] | b;
      end else if (off_r == 6'd34 || off_r == 6'd35) begin
        bits_nxt[{off_r[0], 3'b000} +: 8] = bits_r[{off_r[0], 3'b000} +: 8] | b;
      end else if (off_r >= OFF_CHUNK0 && off_r <= OFF_HDR_LAST) begin
        chunk_en  = 1'b1;
        chunk_pos = off_m36[2:0];
      end
    end else if (phase_r == PH_CHUNK) begin
      chunk_en  = 1'b1;
      chunk_pos = off_r[2:0];
    end

    // chunk header capture: id then little-endian size
    if (chunk_en) begin
      if (!chunk_pos[2]) begin
        if (b != tag_byte(TAG_DATA, chunk_pos[1:0])) cid_nxt = 1'b0;
      end else begin
        size_nxt[{chunk_pos[1:0], 3'b000} +: 8] = size_r[{chunk_pos[1:0], 3'b000} +: 8] | b;
      end
    end

    // per-phase decision
    case (phase_r)
      PH_HEAD: begin
        if (off_r >= OFF_HDR_LAST) begin
          if (!tags_nxt) begin
            rej = 1'b1;
            err = ERR_TAG;
          end else if (format_nxt != FMT_PCM) begin
            rej = 1'b1;
            err = ERR_NOT_PCM;
          end else if (chan_nxt == 16'd0 || rate_nxt == 32'd0 ||
                       (bits_nxt != 16'd8 && bits_nxt != 16'd16)) begin
            rej = 1'b1;
            err = ERR_PARAMS;
          end else begin
            cd = 1'b1;
          end
        end else if (last) begin
          rej = 1'b1;
          err = ERR_SHORT;
        end else begin
          off_nxt = off_r + 6'd1;
        end
      end
      PH_CHUNK: begin
        if (off_r >= OFF_CK_LAST) begin
          cd = 1'b1;
        end else if (last) begin
          rej = 1'b1;
          err = ERR_NO_DATA;
        end else begin
          off_nxt = off_r + 6'd1;
        end
      end
      PH_SKIP: begin
        left_nxt = left_dec;
        if (last) begin
          rej = 1'b1;
          err = ERR_NO_DATA;
        end else if (left_dec == 32'd0) begin
          begin_ck = 1'b1;
        end
      end
      PH_DATA: begin
        push.push0 = 1'b1;
        push.res0  = mk_payload(b);
        deliv_nxt  = deliv_r + 32'd1;
        left_nxt   = left_dec;
        if (left_dec == 32'd0 || last) begin
          acc = 1'b1;
        end
      end
      default: begin
        if (last) restart = 1'b1;
      end
    endcase

    // end of a chunk header
    if (cd) begin
      if (cid_nxt) begin
        if (size_nxt == 32'd0 || last) begin
          acc = 1'b1;
        end else begin
          phase_nxt = PH_DATA;
          left_nxt  = size_nxt;
        end
      end else if (last) begin
        rej = 1'b1;
        err = ERR_NO_DATA;
      end else if (size_nxt == 32'd0) begin
        begin_ck = 1'b1;
      end else begin
        phase_nxt = PH_SKIP;
        left_nxt  = size_nxt;
      end
    end

    // start of the next chunk header
    if (begin_ck) begin
      phase_nxt = PH_CHUNK;
      off_nxt   = 6'd0;
      cid_nxt   = 1'b1;
      size_nxt  = 32'd0;
    end

    // result assembly
    acc_res = mk_accept(chan_nxt, rate_nxt, bits_nxt[4:0], deliv_nxt);
    rej_res = mk_reject(err);
    if (phase_r == PH_DATA) begin
      push.res0.last_of_run = !acc;
      push.push1            = acc;
      push.res1             = acc_res;
      push.res1.last_of_run = 1'b1;
    end else begin
      push.push0            = acc || rej;
      push.res0             = acc ? acc_res : rej_res;
      push.res0.last_of_run = 1'b1;
    end

    // file verdict given
    if (acc || rej) begin
      if (last) restart = 1'b1;
      else phase_nxt = PH_DONE;
    end

    // back to the start of a file
    if (restart) begin
      phase_nxt  = PH_HEAD;
      off_nxt    = 6'd0;
      tags_nxt   = 1'b1;
      format_nxt = 16'd0;
      chan_nxt   = 16'd0;
      rate_nxt   = 32'd0;
      bits_nxt   = 16'd0;
      cid_nxt    = 1'b1;
      size_nxt   = 32'd0;
      left_nxt   = 32'd0;
      deliv_nxt  = 32'd0;
    end

    // nothing moves without an accepted byte
    if (!step) begin
      push.push0 = 1'b0;
      push.push1 = 1'b0;
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEAD;
      off_r    <= 6'd0;
      tags_r   <= 1'b1;
      format_r <= 16'd0;
      chan_r   <= 16'd0;
      rate_r   <= 32'd0;
      bits_r   <= 16'd0;
      cid_r    <= 1'b1;
      size_r   <= 32'd0;
      left_r   <= 32'd0;
      deliv_r  <= 32'd0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      off_r    <= off_nxt;
      tags_r   <= tags_nxt;
      format_r <= format_nxt;
      chan_r   <= chan_nxt;
      rate_r   <= rate_nxt;
      bits_r   <= bits_nxt;
      cid_r    <= cid_nxt;
      size_r   <= size_nxt;
      left_r   <= left_nxt;
      deliv_r  <= deliv_nxt;
    end
  end

endmodule

// File: rtl/wavhp_out_fifo.sv
// ----------------------------------------------------------------------------
// wav header parser result queue
// small queue taking up to two results a cycle, one out a cycle while out_ready is high
// ----------------------------------------------------------------------------
module wavhp_out_fifo (
  input  logic                         clk,
  input  logic                         rst_n,
  input  wavhp_pkg::wavhp_push_t       push,
  input  logic                         out_ready,
  output logic                         out_valid,
  output wavhp_pkg::wavhp_result_t     out_res,
  output wavhp_pkg::wavhp_fifo_stat_t  stat
);
  import wavhp_pkg::*;

  wavhp_result_t         mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt, wr_p1;
  logic [FIFO_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                  pop;
  logic [1:0]            n_push;

  assign out_valid  = (cnt_r != '0);
  assign out_res    = mem[rd_r];
  assign pop        = out_valid && out_ready;
  assign n_push     = {1'b0, push.push0} + {1'b0, push.push1};
  assign wr_p1      = wr_r + 1'b1;
  assign stat.count = cnt_r;
  assign stat.space = (cnt_r <= FIFO_CNT_W'(FIFO_DEPTH - 2));

  // pointer and fill arithmetic
  always_comb begin
    wr_nxt  = wr_r + FIFO_PTR_W'(n_push);
    rd_nxt  = pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + FIFO_CNT_W'(n_push) - FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // storage, second result goes one slot after the first
  always_ff @(posedge clk) begin
    if (push.push0) mem[wr_r] <= push.res0;
    if (push.push1) mem[wr_p1] <= push.res1;
  end

endmodule
